// ----- design/arvs_pkg.sv -----
`timescale 1ns / 1ps
package arvs_pkg;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_CFG   = 2'd1,
    ST_NO_TARGET = 2'd2
  } status_t;

  // Register indexes on the configuration port (word address).
  localparam logic [2:0] REG_MAX_SPEED      = 3'd0;
  localparam logic [2:0] REG_TARGET_RADIUS  = 3'd1;
  localparam logic [2:0] REG_SLOW_RADIUS    = 3'd2;
  localparam logic [2:0] REG_TIME_TO_TARGET = 3'd3;
  localparam logic [2:0] REG_MAX_ACCEL      = 3'd4;

  localparam logic [31:0] RST_MAX_SPEED      = 32'd153600;
  localparam logic [31:0] RST_TARGET_RADIUS  = 32'd2560;
  localparam logic [31:0] RST_SLOW_RADIUS    = 32'd51200;
  localparam logic [15:0] RST_TIME_TO_TARGET = 16'd26;
  localparam logic [31:0] RST_MAX_ACCEL      = 32'd5120;

  typedef struct packed {
    logic [31:0] max_speed;
    logic [31:0] target_radius;
    logic [31:0] slow_radius;
    logic [15:0] time_to_target;
    logic [31:0] max_acceleration;
  } cfg_t;

  // Classification handed from the front end to the back end.
  typedef struct packed {
    status_t    status;
    logic [2:0] neg;
  } cls_t;

endpackage

// ----- design/arvs_front.sv -----
`timescale 1ns / 1ps
module arvs_front #(
  parameter int COORD_WIDTH = 32
) (
  input  arvs_pkg::cfg_t                cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_agent_pos_x,
  input  logic signed [COORD_WIDTH-1:0] in_agent_pos_y,
  input  logic signed [COORD_WIDTH-1:0] in_agent_pos_z,
  input  logic signed [COORD_WIDTH-1:0] in_goal_pos_x,
  input  logic signed [COORD_WIDTH-1:0] in_goal_pos_y,
  input  logic signed [COORD_WIDTH-1:0] in_goal_pos_z,
  input  logic signed [COORD_WIDTH-1:0] in_agent_vel_x,
  input  logic signed [COORD_WIDTH-1:0] in_agent_vel_y,
  input  logic signed [COORD_WIDTH-1:0] in_agent_vel_z,
  input  logic                          in_goal_is_actor,
  input  logic                          q_full,
  output logic                          q_push,
  output arvs_pkg::cls_t                q_cls,
  output logic [3*(COORD_WIDTH+1)-1:0]  q_ad,
  output logic [3*COORD_WIDTH-1:0]      q_vel
);
  import arvs_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int AW = W + 1;

  logic [W-1:0]        apos [3];
  logic [W-1:0]        gpos [3];
  logic signed [W:0]   d    [3];
  logic                cfg_bad;
  logic                no_target;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;
  assign q_vel    = {in_agent_vel_z, in_agent_vel_y, in_agent_vel_x};

  always_comb begin
    apos[0] = in_agent_pos_x;
    apos[1] = in_agent_pos_y;
    apos[2] = in_agent_pos_z;
    gpos[0] = in_goal_pos_x;
    gpos[1] = in_goal_pos_y;
    gpos[2] = in_goal_pos_z;
    for (int i = 0; i < 3; i++) begin
      d[i] = $signed({gpos[i][W-1], gpos[i]}) - $signed({apos[i][W-1], apos[i]});
      q_ad[i*AW +: AW] = d[i][W] ? AW'(-d[i]) : AW'(d[i]);
      q_cls.neg[i] = d[i][W];
    end

    cfg_bad = ($signed(cfg.max_speed) <= 0) || $signed(cfg.target_radius) < 0 ||
              ($signed(cfg.slow_radius) < $signed(cfg.target_radius)) ||
              $signed(cfg.time_to_target) < 0 || $signed(cfg.max_acceleration) < 0;
    no_target = !in_goal_is_actor && (gpos[0] == '0) && (gpos[1] == '0) &&
                (gpos[2] == '0);

    priority if (cfg_bad) begin
      q_cls.status = ST_BAD_CFG;
    end else if (no_target) begin
      q_cls.status = ST_NO_TARGET;
    end else begin
      q_cls.status = ST_OK;
    end
  end

endmodule

// ----- design/arvs_fifo.sv -----
`timescale 1ns / 1ps
module arvs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             rvalid,
  output logic [WIDTH-1:0] rdata
);

  localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTRW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTRW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0]  count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNTW'(DEPTH));
  assign rvalid  = (count_r != '0);
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && rvalid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ----- design/arvs_back.sv -----
`timescale 1ns / 1ps
module arvs_back #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  arvs_pkg::cfg_t                cfg,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  arvs_pkg::cls_t                q_cls,
  input  logic [3*(COORD_WIDTH+1)-1:0]  q_ad,
  input  logic [3*COORD_WIDTH-1:0]      q_vel,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] out_accel_x,
  output logic signed [COORD_WIDTH-1:0] out_accel_y,
  output logic signed [COORD_WIDTH-1:0] out_accel_z,
  output logic                          out_arrived,
  output arvs_pkg::status_t             out_status
);
  import arvs_pkg::*;

  localparam int W   = COORD_WIDTH;
  localparam int AW  = W + 1;                     // |offset|
  localparam int SW  = 2 * W + 2;                 // squared length
  localparam int CW  = (SW > 62) ? SW : 62;       // radius compare
  localparam int NW  = AW + 31;                   // |offset| * max_speed
  localparam int DVW = (AW > 31) ? AW : 31;       // speed divisor
  localparam int XW  = DVW + 31;                  // speed divider remainder
  localparam int QB  = 31;                        // desired speed bits
  localparam int FW  = ((W > 32) ? W : 32) + 1;   // velocity difference
  localparam int RW  = ((FW + 8) > (W + 15)) ? FW + 8 : W + 15;
  localparam int PW  = 5 + 3 * W;                 // {status, neg, vel}
  localparam int SQW = PW + 2 + 3 * NW;           // {pside, arrived, fast, num}
  localparam int DSW = PW + 2 + DVW;              // {pside, arrived, dv, dvz}
  localparam int L   = W + 1;                     // last root stage

  logic adv;
  logic out_valid_r;
  assign adv       = !out_valid_r || out_ready;
  assign q_ready   = adv;
  assign out_valid = out_valid_r;

  // Squared radii are registered from the radius registers and follow them in the next cycle.
  logic [61:0] trsq_r, srsq_r;
  always_ff @(posedge clk) begin
    trsq_r <= 62'(cfg.target_radius[30:0]) * 62'(cfg.target_radius[30:0]);
    srsq_r <= 62'(cfg.slow_radius[30:0]) * 62'(cfg.slow_radius[30:0]);
  end

  // Stage 1: squares and speed products.
  logic          s1_v_r;
  logic [SW-1:0] s1_sq_r  [3];
  logic [SW-1:0] s1_sq_nxt[3];
  logic [NW-1:0] s1_num_r [3];
  logic [NW-1:0] s1_num_nxt[3];
  logic [PW-1:0] s1_side_r, s1_side_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s1_sq_nxt[i]  = SW'(q_ad[i*AW +: AW]) * SW'(q_ad[i*AW +: AW]);
      s1_num_nxt[i] = NW'(q_ad[i*AW +: AW]) * NW'(cfg.max_speed[30:0]);
    end
    s1_side_nxt = {q_cls.status, q_cls.neg, q_vel};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_sq_r   <= s1_sq_nxt;
      s1_num_r  <= s1_num_nxt;
      s1_side_r <= s1_side_nxt;
    end
  end

  // Stage 2 (root index 0): length squared against both radii.
  logic           sq_v_r    [0:L];
  logic [SW-1:0]  sq_rem_r  [0:L];
  logic [AW-1:0]  sq_root_r [0:L];
  logic [SQW-1:0] sq_side_r [0:L];
  logic [SW-1:0]  sum_nxt;
  logic           arr_nxt, fast_nxt;

  always_comb begin
    sum_nxt  = s1_sq_r[0] + s1_sq_r[1] + s1_sq_r[2];
    arr_nxt  = CW'(sum_nxt) < CW'(trsq_r);
    fast_nxt = CW'(sum_nxt) > CW'(srsq_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else if (adv) begin
      sq_v_r[0] <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_rem_r[0]  <= sum_nxt;
      sq_root_r[0] <= '0;
      sq_side_r[0] <= {s1_side_r, arr_nxt, fast_nxt, s1_num_r[2], s1_num_r[1], s1_num_r[0]};
    end
  end

  // Integer square root, one result bit per stage. Trying root bit b adds
  // (root << (b+1)) + (1 << 2b) to the square, taken from the remainder.
  for (genvar j = 1; j <= L; j++) begin : g_root
    localparam int B = L - j;
    logic [SW-1:0] inc, rem_nxt;
    logic [AW-1:0] root_nxt;

    always_comb begin
      inc      = (SW'(sq_root_r[j-1]) << (B + 1)) + (SW'(1'b1) << (2 * B));
      rem_nxt  = sq_rem_r[j-1];
      root_nxt = sq_root_r[j-1];
      if (inc <= sq_rem_r[j-1]) begin
        rem_nxt  = sq_rem_r[j-1] - inc;
        root_nxt = sq_root_r[j-1] | (AW'(1'b1) << B);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[j] <= 1'b0;
      end else if (adv) begin
        sq_v_r[j] <= sq_v_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_rem_r[j]  <= rem_nxt;
        sq_root_r[j] <= root_nxt;
        sq_side_r[j] <= sq_side_r[j-1];
      end
    end
  end

  // Desired speed per axis: |d_i| * max_speed over the length or slow_radius.
  logic           dv_v_r    [0:QB];
  logic [XW-1:0]  dv_rem_r  [0:QB][3];
  logic [QB-1:0]  dv_q_r    [0:QB][3];
  logic [DSW-1:0] dv_side_r [0:QB];
  logic [DVW-1:0] dvs_nxt;

  always_comb begin
    dvs_nxt = sq_side_r[L][3*NW] ? DVW'(sq_root_r[L]) : DVW'(cfg.slow_radius[30:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (adv) begin
      dv_v_r[0] <= sq_v_r[L];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        dv_rem_r[0][i] <= XW'(sq_side_r[L][i*NW +: NW]);
        dv_q_r[0][i]   <= '0;
      end
      dv_side_r[0] <= {sq_side_r[L][SQW-1 -: PW], sq_side_r[L][3*NW+1], dvs_nxt,
                       dvs_nxt == '0};
    end
  end

  for (genvar j = 1; j <= QB; j++) begin : g_spd
    localparam int B = QB - j;
    logic [XW-1:0] t;
    logic [XW-1:0] rem_nxt [3];
    logic [QB-1:0] q_nxt   [3];

    always_comb begin
      t = XW'(dv_side_r[j-1][DVW:1]) << B;
      for (int i = 0; i < 3; i++) begin
        rem_nxt[i] = dv_rem_r[j-1][i];
        q_nxt[i]   = dv_q_r[j-1][i];
        if (t <= dv_rem_r[j-1][i]) begin
          rem_nxt[i] = dv_rem_r[j-1][i] - t;
          q_nxt[i]   = dv_q_r[j-1][i] | (QB'(1'b1) << B);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[j] <= 1'b0;
      end else if (adv) begin
        dv_v_r[j] <= dv_v_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_rem_r[j]  <= rem_nxt;
        dv_q_r[j]    <= q_nxt;
        dv_side_r[j] <= dv_side_r[j-1];
      end
    end
  end

  // Velocity difference and its magnitude.
  logic [PW-1:0]         pside;
  logic signed [FW-1:0]  p1_qs   [3];
  logic signed [FW-1:0]  p1_vd   [3];
  logic signed [FW-1:0]  p1_diff [3];
  logic [FW-1:0]         p1_mag_nxt[3];
  logic [2:0]            p1_neg_nxt;
  logic [W-1:0]          p1_vel  [3];
  logic                  p1_v_r;
  logic [FW-1:0]         p1_mag_r[3];
  logic [2:0]            p1_neg_r;
  logic [2:0]            p1_side_r;

  always_comb begin
    pside = dv_side_r[QB][DSW-1 -: PW];
    for (int i = 0; i < 3; i++) begin
      p1_vel[i] = pside[i*W +: W];
      p1_qs[i]  = dv_side_r[QB][0] ? '0 : $signed({{(FW-QB){1'b0}}, dv_q_r[QB][i]});
      p1_vd[i]  = pside[3*W+i] ? -p1_qs[i] : p1_qs[i];
      p1_diff[i] = p1_vd[i] - $signed({{(FW-W){p1_vel[i][W-1]}}, p1_vel[i]});
      p1_neg_nxt[i] = p1_diff[i][FW-1];
      p1_mag_nxt[i] = p1_neg_nxt[i] ? FW'(-p1_diff[i]) : FW'(p1_diff[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
    end else if (adv) begin
      p1_v_r <= dv_v_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_mag_r  <= p1_mag_nxt;
      p1_neg_r  <= p1_neg_nxt;
      p1_side_r <= {pside[PW-1 -: 2], dv_side_r[QB][DVW+1]};
    end
  end

  // Division by time_to_target. The saturation test is made up front, so the
  // quotient needs only COORD_WIDTH bits.
  logic [14:0]   ttt;
  logic          tt_v_r    [0:W];
  logic [RW-1:0] tt_rem_r  [0:W][3];
  logic [W-1:0]  tt_q_r    [0:W][3];
  logic [2:0]    tt_sat_r  [0:W];
  logic [2:0]    tt_zero_r [0:W];
  logic [2:0]    tt_neg_r  [0:W];
  logic [2:0]    tt_side_r [0:W];
  logic [RW-1:0] tt_n_nxt  [3];
  logic [RW-1:0] tt_thr_nxt[3];
  logic [2:0]    tt_sat_nxt, tt_zero_nxt;

  assign ttt = cfg.time_to_target[14:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tt_n_nxt[i]   = RW'(p1_mag_r[i]) << 8;
      tt_thr_nxt[i] = (RW'(ttt) << (W - 1)) + (p1_neg_r[i] ? RW'(ttt) : RW'(1'b0));
      tt_sat_nxt[i]  = tt_n_nxt[i] >= tt_thr_nxt[i];
      tt_zero_nxt[i] = p1_mag_r[i] == '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tt_v_r[0] <= 1'b0;
    end else if (adv) begin
      tt_v_r[0] <= p1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        tt_rem_r[0][i] <= tt_n_nxt[i];
        tt_q_r[0][i]   <= '0;
      end
      tt_sat_r[0]  <= tt_sat_nxt;
      tt_zero_r[0] <= tt_zero_nxt;
      tt_neg_r[0]  <= p1_neg_r;
      tt_side_r[0] <= p1_side_r;
    end
  end

  for (genvar j = 1; j <= W; j++) begin : g_ttt
    localparam int B = W - j;
    logic [RW-1:0] t;
    logic [RW-1:0] rem_nxt [3];
    logic [W-1:0]  q_nxt   [3];

    always_comb begin
      t = RW'(ttt) << B;
      for (int i = 0; i < 3; i++) begin
        rem_nxt[i] = tt_rem_r[j-1][i];
        q_nxt[i]   = tt_q_r[j-1][i];
        if (t <= tt_rem_r[j-1][i]) begin
          rem_nxt[i] = tt_rem_r[j-1][i] - t;
          q_nxt[i]   = tt_q_r[j-1][i] | (W'(1'b1) << B);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tt_v_r[j] <= 1'b0;
      end else if (adv) begin
        tt_v_r[j] <= tt_v_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        tt_rem_r[j]  <= rem_nxt;
        tt_q_r[j]    <= q_nxt;
        tt_sat_r[j]  <= tt_sat_r[j-1];
        tt_zero_r[j] <= tt_zero_r[j-1];
        tt_neg_r[j]  <= tt_neg_r[j-1];
        tt_side_r[j] <= tt_side_r[j-1];
      end
    end
  end

  // Output register.
  logic           out_valid_nxt;
  logic [W-1:0]   acc_nxt [3];
  logic [W-1:0]   out_acc_r [3];
  logic           out_arr_r, out_arr_nxt;
  status_t        out_st_r, out_st_nxt;

  always_comb begin
    out_valid_nxt = adv ? tt_v_r[W] : out_valid_r;
    out_st_nxt    = status_t'(tt_side_r[W][2:1]);
    out_arr_nxt   = tt_side_r[W][0];
    for (int i = 0; i < 3; i++) begin
      priority if (tt_zero_r[W][i]) begin
        acc_nxt[i] = '0;
      end else if (tt_sat_r[W][i]) begin
        acc_nxt[i] = tt_neg_r[W][i] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      end else begin
        acc_nxt[i] = tt_neg_r[W][i] ? (~tt_q_r[W][i] + 1'b1) : tt_q_r[W][i];
      end
    end
    if (out_st_nxt != ST_OK) begin
      out_arr_nxt = 1'b0;
      for (int i = 0; i < 3; i++) begin
        acc_nxt[i] = '0;
      end
    end else if (out_arr_nxt) begin
      for (int i = 0; i < 3; i++) begin
        acc_nxt[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_acc_r <= acc_nxt;
      out_arr_r <= out_arr_nxt;
      out_st_r  <= out_st_nxt;
    end
  end

  assign out_accel_x = out_acc_r[0];
  assign out_accel_y = out_acc_r[1];
  assign out_accel_z = out_acc_r[2];
  assign out_arrived = out_arr_r;
  assign out_status  = out_st_r;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_st_r != ST_OK) |->
      (!out_arr_r && out_acc_r[0] == '0 && out_acc_r[1] == '0 && out_acc_r[2] == '0))
    else $error("error status with nonzero result");

  a_arrive_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_arr_r) |->
      (out_st_r == ST_OK && out_acc_r[0] == '0 && out_acc_r[1] == '0 &&
       out_acc_r[2] == '0))
    else $error("arrival with nonzero acceleration");

  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> ($stable(tt_v_r[W]) && $stable(sq_v_r[L]) && $stable(s1_v_r)))
    else $error("pipeline moved while stalled");

endmodule

// ----- design/arrive_steering_top.sv -----
`timescale 1ns / 1ps
// Arrive steering unit.
// Input channel (in_valid/in_ready): one word holds the agent position and
// velocity, the goal position and the goal-is-actor flag. Output channel
// (out_valid/out_ready): one word with the acceleration, the arrived flag and
// a status code, one result word for every input word, in order.
// Registers sit on an APB-style port at byte addresses 0, 4, 8, 12 and 16;
// write them only while no word is in flight.
// Most of the pipeline depth lies in the root stages (one bit each), the 31
// stages of the speed divider and the COORD_WIDTH stages of the time divider.
// Throughput is one word per cycle while the output is not stalled: every
// unit is fully pipelined.
// A four-entry queue separates the input checks from the arithmetic pipeline.
// When out_ready is low with out_valid high, the whole pipeline holds, the queue
// fills and in_ready falls once it is full; no word is dropped.
// Reset empties the queue and the pipeline and loads the registers with their
// default values.
module arrive_steering_top #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_agent_pos_x,
  input  logic signed [COORD_WIDTH-1:0] in_agent_pos_y,
  input  logic signed [COORD_WIDTH-1:0] in_agent_pos_z,
  input  logic signed [COORD_WIDTH-1:0] in_goal_pos_x,
  input  logic signed [COORD_WIDTH-1:0] in_goal_pos_y,
  input  logic signed [COORD_WIDTH-1:0] in_goal_pos_z,
  input  logic signed [COORD_WIDTH-1:0] in_agent_vel_x,
  input  logic signed [COORD_WIDTH-1:0] in_agent_vel_y,
  input  logic signed [COORD_WIDTH-1:0] in_agent_vel_z,
  input  logic                          in_goal_is_actor,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] out_accel_x,
  output logic signed [COORD_WIDTH-1:0] out_accel_y,
  output logic signed [COORD_WIDTH-1:0] out_accel_z,
  output logic                          out_arrived,
  output arvs_pkg::status_t             out_status,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [4:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import arvs_pkg::*;

  localparam int W    = COORD_WIDTH;
  localparam int AW   = W + 1;
  localparam int CLSW = $bits(cls_t);
  localparam int EW   = CLSW + 3 * AW + 3 * W;

  logic [31:0] max_speed_r, target_radius_r, slow_radius_r, max_accel_r;
  logic [15:0] ttt_r;
  logic [2:0]  reg_idx;
  logic        wr_en;
  cfg_t        cfg;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_speed_r     <= RST_MAX_SPEED;
      target_radius_r <= RST_TARGET_RADIUS;
      slow_radius_r   <= RST_SLOW_RADIUS;
      ttt_r           <= RST_TIME_TO_TARGET;
      max_accel_r     <= RST_MAX_ACCEL;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_MAX_SPEED:      max_speed_r     <= pwdata;
        REG_TARGET_RADIUS:  target_radius_r <= pwdata;
        REG_SLOW_RADIUS:    slow_radius_r   <= pwdata;
        REG_TIME_TO_TARGET: ttt_r           <= pwdata[15:0];
        REG_MAX_ACCEL:      max_accel_r     <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MAX_SPEED:      prdata = max_speed_r;
      REG_TARGET_RADIUS:  prdata = target_radius_r;
      REG_SLOW_RADIUS:    prdata = slow_radius_r;
      REG_TIME_TO_TARGET: prdata = {16'd0, ttt_r};
      REG_MAX_ACCEL:      prdata = max_accel_r;
      default:            prdata = '0;
    endcase
  end

  assign cfg = '{max_speed: max_speed_r, target_radius: target_radius_r,
                 slow_radius: slow_radius_r, time_to_target: ttt_r,
                 max_acceleration: max_accel_r};

  logic              f_push, q_full, q_valid, q_ready;
  cls_t              f_cls, q_cls;
  logic [3*AW-1:0]   f_ad;
  logic [3*W-1:0]    f_vel;
  logic [EW-1:0]     q_data;

  arvs_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .cfg              (cfg),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_agent_pos_x   (in_agent_pos_x),
    .in_agent_pos_y   (in_agent_pos_y),
    .in_agent_pos_z   (in_agent_pos_z),
    .in_goal_pos_x    (in_goal_pos_x),
    .in_goal_pos_y    (in_goal_pos_y),
    .in_goal_pos_z    (in_goal_pos_z),
    .in_agent_vel_x   (in_agent_vel_x),
    .in_agent_vel_y   (in_agent_vel_y),
    .in_agent_vel_z   (in_agent_vel_z),
    .in_goal_is_actor (in_goal_is_actor),
    .q_full           (q_full),
    .q_push           (f_push),
    .q_cls            (f_cls),
    .q_ad             (f_ad),
    .q_vel            (f_vel)
  );

  arvs_fifo #(.WIDTH(EW), .DEPTH(4)) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (f_push),
    .wdata  ({f_cls, f_ad, f_vel}),
    .full   (q_full),
    .pop    (q_ready),
    .rvalid (q_valid),
    .rdata  (q_data)
  );

  assign q_cls = cls_t'(q_data[EW-1 -: CLSW]);

  arvs_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .q_valid     (q_valid),
    .q_ready     (q_ready),
    .q_cls       (q_cls),
    .q_ad        (q_data[3*W +: 3*AW]),
    .q_vel       (q_data[3*W-1:0]),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_accel_x (out_accel_x),
    .out_accel_y (out_accel_y),
    .out_accel_z (out_accel_z),
    .out_arrived (out_arrived),
    .out_status  (out_status)
  );

endmodule

// ----- tb/sv/arrive_steering_top_test.sv -----
`timescale 1ns / 1ps
module arrive_steering_top_test;
  import arvs_pkg::*;

  localparam int LATENCY = 2 * 32 + 38;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [2:0][31:0] apos;
    logic [2:0][31:0] gpos;
    logic [2:0][31:0] avel;
    logic             actor;
  } steer_word_t;

  typedef struct packed {
    logic [2:0][31:0] acc;
    logic             arr;
    status_t          st;
  } steer_res_t;

  typedef struct packed {
    steer_word_t w;
    logic        typed;
    steer_res_t  r;
  } vec_row_t;

  localparam steer_res_t NO_RES = '0;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] in_agent_pos_x = '0, in_agent_pos_y = '0, in_agent_pos_z = '0;
  logic signed [31:0] in_goal_pos_x = '0, in_goal_pos_y = '0, in_goal_pos_z = '0;
  logic signed [31:0] in_agent_vel_x = '0, in_agent_vel_y = '0, in_agent_vel_z = '0;
  logic in_goal_is_actor = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_accel_x, out_accel_y, out_accel_z;
  logic out_arrived;
  status_t out_status;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  arrive_steering_top uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Local copy of the registers.
  logic [31:0] speed_r = RST_MAX_SPEED, tgt_rad_r = RST_TARGET_RADIUS;
  logic [31:0] slow_rad_r = RST_SLOW_RADIUS, max_acc_r = RST_MAX_ACCEL;
  logic [15:0] ttt_r = RST_TIME_TO_TARGET;

  steer_res_t pending_accel[$];
  vec_row_t   vec_rows[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit quiet_rx = 0;

  function automatic steer_res_t predict_accel(steer_word_t w);
    steer_res_t r;
    longint ms, tr, sr, ttt, macc, lim, vd, diff, acc;
    longint d[3];
    logic [127:0] sum, root, t, a128, q, aq;
    bit fast;
    r = '0;
    r.st = ST_OK;
    ms = longint'($signed(speed_r));
    tr = longint'($signed(tgt_rad_r));
    sr = longint'($signed(slow_rad_r));
    ttt = longint'($signed(ttt_r));
    macc = longint'($signed(max_acc_r));
    lim = 64'h7fffffff;
    if (ms <= 0 || tr < 0 || sr < tr || ttt < 0 || macc < 0) begin
      r.st = ST_BAD_CFG;
      return r;
    end
    if (!w.actor && w.gpos == '0) begin
      r.st = ST_NO_TARGET;
      return r;
    end
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      d[i] = longint'($signed(w.gpos[i])) - longint'($signed(w.apos[i]));
      a128 = d[i] < 0 ? -d[i] : d[i];
      sum = sum + a128 * a128;
    end
    if (sum < 128'(tr) * 128'(tr)) begin
      r.arr = 1'b1;
      return r;
    end
    fast = sum > 128'(sr) * 128'(sr);
    root = '0;
    if (fast) begin
      for (int b = 50; b >= 0; b--) begin
        t = root | (128'd1 << b);
        if (t * t <= sum) root = t;
      end
    end
    for (int i = 0; i < 3; i++) begin
      a128 = d[i] < 0 ? -d[i] : d[i];
      if (fast) q = (a128 * 128'(ms)) / root;
      else if (sr > 0) q = (a128 * 128'(ms)) / 128'(sr);
      else q = '0;
      vd = d[i] < 0 ? -longint'(q) : longint'(q);
      diff = vd - longint'($signed(w.avel[i]));
      if (ttt == 0) begin
        acc = diff > 0 ? lim : (diff < 0 ? -lim - 1 : 0);
      end else begin
        a128 = diff < 0 ? -diff : diff;
        aq = (a128 * 128'd256) / 128'(ttt);
        if (aq > 128'(lim)) acc = diff < 0 ? -lim - 1 : lim;
        else acc = diff < 0 ? -longint'(aq) : longint'(aq);
      end
      r.acc[i] = acc[31:0];
    end
    return r;
  endfunction

  function automatic steer_word_t mk_word(longint ax, ay, az, gx, gy, gz, vx, vy, vz,
                                          bit actor);
    steer_word_t w;
    w.apos = {32'(az), 32'(ay), 32'(ax)};
    w.gpos = {32'(gz), 32'(gy), 32'(gx)};
    w.avel = {32'(vz), 32'(vy), 32'(vx)};
    w.actor = actor;
    return w;
  endfunction

  function automatic steer_res_t mk_res(bit arr, status_t st);
    steer_res_t r;
    r = '0;
    r.arr = arr;
    r.st = st;
    return r;
  endfunction

  function automatic logic [31:0] rand_scaled(int k);
    return $signed($urandom) >>> (31 - k);
  endfunction

  function automatic steer_word_t rand_word();
    steer_word_t w;
    int kind;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 3; i++) begin
      w.apos[i] = $urandom;
      w.gpos[i] = $urandom;
      w.avel[i] = $urandom;
    end
    w.actor = $urandom_range(0, 1);
    if (kind == 1) begin
      w.gpos = '0;
    end else if (kind >= 2) begin
      for (int i = 0; i < 3; i++) begin
        w.apos[i] = rand_scaled(28);
        w.gpos[i] = w.apos[i] + rand_scaled(8 + 4 * $urandom_range(0, 3));
        w.avel[i] = rand_scaled($urandom_range(4, 31));
      end
      w.actor = $urandom_range(0, 3) != 0;
    end
    return w;
  endfunction

  function automatic int gap_len();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(20, 200) : $urandom_range(0, 3);
  endfunction

  task automatic cfg_write(logic [2:0] idx, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic load_regs(logic [31:0] ms, tr, sr, logic [15:0] ttt, logic [31:0] macc);
    cfg_write(REG_MAX_SPEED, ms);
    cfg_write(REG_TARGET_RADIUS, tr);
    cfg_write(REG_SLOW_RADIUS, sr);
    cfg_write(REG_TIME_TO_TARGET, {16'd0, ttt});
    cfg_write(REG_MAX_ACCEL, macc);
    speed_r = ms;
    tgt_rad_r = tr;
    slow_rad_r = sr;
    ttt_r = ttt;
    max_acc_r = macc;
  endtask

  // Holds the word until it is accepted, then queues its expected result.
  task automatic send_word(steer_word_t w, bit typed, steer_res_t r);
    in_valid <= 1'b1;
    {in_agent_pos_z, in_agent_pos_y, in_agent_pos_x} <= w.apos;
    {in_goal_pos_z, in_goal_pos_y, in_goal_pos_x} <= w.gpos;
    {in_agent_vel_z, in_agent_vel_y, in_agent_vel_x} <= w.avel;
    in_goal_is_actor <= w.actor;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_accel.push_back(typed ? r : predict_accel(w));
  endtask

  task automatic send_gap(bit busy);
    int n;
    n = busy ? 0 : gap_len();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_accel.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  task automatic run_random(int count);
    bit busy;
    busy = $urandom_range(0, 3) == 0;
    quiet_rx = $urandom_range(0, 3) == 0;
    for (int k = 0; k < count; k++) begin
      send_word(rand_word(), 1'b0, '0);
      send_gap(busy);
    end
    drain();
  endtask

  // Output side: random backpressure and the in-order compare.
  int stall_left = 0, run_left = 0;
  steer_res_t want;
  always @(posedge clk) begin
    if (in_valid && in_ready || out_valid && out_ready) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
    if (out_valid && out_ready) begin
      if (pending_accel.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result word");
      end else begin
        want = pending_accel.pop_front();
        if (out_accel_x !== want.acc[0] || out_accel_y !== want.acc[1] ||
            out_accel_z !== want.acc[2] || out_arrived !== want.arr ||
            out_status !== want.st) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: exp %0d %0d %0d arr %0b st %0d, got %0d %0d %0d arr %0b st %0d",
                     $signed(want.acc[0]), $signed(want.acc[1]), $signed(want.acc[2]),
                     want.arr, want.st, out_accel_x, out_accel_y, out_accel_z,
                     out_arrived, out_status);
        end
      end
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (quiet_rx) begin
      out_ready <= 1'b1;
    end else if (run_left > 0) begin
      run_left <= run_left - 1;
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      run_left <= $urandom_range(1, 30);
      stall_left <= gap_len();
      out_ready <= 1'b1;
    end
  end

  initial begin
    vec_row_t row;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words under the reset register values.
    vec_rows.push_back({mk_word(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                        mk_res(0, ST_NO_TARGET)});
    vec_rows.push_back({mk_word(5000, -7, 9, 0, 0, 0, 100, 100, 100, 0), 1'b1,
                        mk_res(0, ST_NO_TARGET)});
    vec_rows.push_back({mk_word(0, 0, 0, 0, 0, 0, 300, -300, 0, 1), 1'b1,
                        mk_res(1, ST_OK)});
    vec_rows.push_back({mk_word(0, 0, 0, 1000, 0, 0, 0, 0, 0, 0), 1'b1,
                        mk_res(1, ST_OK)});
    vec_rows.push_back({mk_word(0, 0, 0, 2560, 0, 0, 0, 0, 0, 0), 1'b0, NO_RES});
    vec_rows.push_back({mk_word(0, 0, 0, 0, -2559, 0, 0, 0, 0, 0), 1'b0, NO_RES});
    vec_rows.push_back({mk_word(0, 0, 0, 51200, 0, 0, 0, 0, 0, 0), 1'b0, NO_RES});
    vec_rows.push_back({mk_word(0, 0, 0, 0, 0, -51201, 0, 0, 0, 0), 1'b0, NO_RES});
    vec_rows.push_back({mk_word(0, 0, 0, 300000, 400000, 0, 0, 0, 0, 1), 1'b0, NO_RES});
    vec_rows.push_back({mk_word(-9000, 4000, 100, -20000, 30000, -5000,
                                7000, -3000, 12, 1), 1'b0, NO_RES});
    vec_rows.push_back({mk_word(0, 0, 0, 0, 0, 1, 0, 0, 0, 0), 1'b0, NO_RES});
    vec_rows.push_back({mk_word(2147483647, 2147483647, 2147483647,
                                -2147483648, -2147483648, -2147483648,
                                2147483647, 2147483647, 2147483647, 1), 1'b0, NO_RES});
    vec_rows.push_back({mk_word(-2147483648, -2147483648, -2147483648,
                                2147483647, 2147483647, 2147483647,
                                -2147483648, -2147483648, -2147483648, 0), 1'b0, NO_RES});
    vec_rows.push_back({mk_word(0, 0, 0, 60000, 0, 0, -2147483648, 2147483647, 0, 1),
                        1'b0, NO_RES});
    foreach (vec_rows[i]) begin
      row = vec_rows[i];
      send_word(row.w, row.typed, row.r);
      send_gap(1'b0);
    end
    drain();

    // Extremes of the register ranges, valid and invalid.
    load_regs(32'h7fffffff, 32'd0, 32'd0, 16'd0, 32'd0);
    run_random(150);
    load_regs(32'd1, 32'd0, 32'h7fffffff, 16'h7fff, 32'h7fffffff);
    run_random(150);
    load_regs(32'd0, 32'd2560, 32'd51200, 16'd26, 32'd5120);
    run_random(30);
    load_regs(32'h80000000, 32'd2560, 32'd51200, 16'd26, 32'd5120);
    run_random(30);
    load_regs(32'd153600, 32'hffffffff, 32'd51200, 16'd26, 32'd5120);
    run_random(30);
    load_regs(32'd153600, 32'd51201, 32'd51200, 16'd26, 32'd5120);
    run_random(30);
    load_regs(32'd153600, 32'd2560, 32'd51200, 16'h8000, 32'd5120);
    run_random(30);
    load_regs(32'd153600, 32'd2560, 32'd51200, 16'd26, 32'h80000000);
    run_random(30);
    // Random valid settings.
    for (int p = 0; p < 5; p++) begin
      int tr;
      tr = $urandom_range(0, 20000);
      load_regs($urandom_range(1, 1 << 20), tr, tr + $urandom_range(0, 100000),
                16'($urandom_range(1, 1000)), $urandom_range(0, 32'h7fffffff));
      run_random(150);
    end

    if (mismatches == 0 && pending_accel.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
